/* hw/rtl/heightmap_triangle_height_sampler_top_assert.svh */
// Assertion helpers for the height sampler, clocked on clk_i, off during reset.
`ifndef HEIGHTMAP_TRIANGLE_HEIGHT_SAMPLER_TOP_ASSERT_SVH
`define HEIGHTMAP_TRIANGLE_HEIGHT_SAMPLER_TOP_ASSERT_SVH
// same-cycle implication
`define HMTS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define HMTS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

/* hw/rtl/hmts_pkg.sv */
package hmts_pkg;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam int CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_GRID_LENGTH   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_CELL_SPACING  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_ORIGIN_X      = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_ORIGIN_Z      = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_ORIGIN_HEIGHT = 3'd4;

  localparam int HW      = 32;  // heights and coordinates
  localparam int SpW     = 10;  // cell spacing
  localparam int LenCfgW = 9;   // grid length register
  localparam int CellW   = 8;   // write cell index fields

  // offset divider: 33-bit magnitude, three quotient bits per stage
  localparam int DivW      = HW + 1;
  localparam int DivSteps  = 3;
  localparam int DivStages = DivW / DivSteps;
  localparam int PW        = DivW + 1;  // signed floor quotient

  localparam int QDepth = 4;

  typedef struct packed {
    logic           neg;
    logic [SpW-1:0] rem;
    logic [DivW-1:0] nq;   // dividend bits shifting out, quotient bits in
  } div_lane_t;

  function automatic div_lane_t div_step(div_lane_t s, logic [SpW-1:0] sp);
    logic [SpW:0] t;
    logic         ge;
    div_lane_t    r;
    t     = {s.rem, s.nq[DivW-1]};
    ge    = t >= {1'b0, sp};
    r.neg = s.neg;
    r.rem = ge ? SpW'(t - {1'b0, sp}) : t[SpW-1:0];
    r.nq  = {s.nq[DivW-2:0], ge};
    return r;
  endfunction

  function automatic div_lane_t lane_run(div_lane_t s, logic [SpW-1:0] sp);
    div_lane_t r;
    r = s;
    for (int k = 0; k < DivSteps; k++) begin
      r = div_step(r, sp);
    end
    return r;
  endfunction

  function automatic div_lane_t lane_init(logic signed [DivW-1:0] d);
    div_lane_t r;
    r.neg = d[DivW-1];
    r.rem = '0;
    r.nq  = r.neg ? DivW'(-d) : DivW'(d);
    return r;
  endfunction

  // floor division result from magnitude quotient and remainder
  function automatic logic signed [PW-1:0] lane_quot(div_lane_t s);
    logic signed [PW-1:0] q;
    q = $signed({1'b0, s.nq});
    if (s.neg) begin
      q = -q;
      if (s.rem != '0) q = q - 1;
    end
    return q;
  endfunction

endpackage

/* hw/rtl/hmts_ram.sv */
module hmts_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] wa_i,
  input  logic [W-1:0]             wd_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] ra0_i,
  input  logic [$clog2(DEPTH)-1:0] ra1_i,
  output logic [W-1:0]             rd0_o,
  output logic [W-1:0]             rd1_o
);

  logic [W-1:0] mem_q [DEPTH];
  logic [W-1:0] rd0_q, rd1_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[wa_i] <= wd_i;
    if (re_i) begin
      rd0_q <= mem_q[ra0_i];
      rd1_q <= mem_q[ra1_i];
    end
  end

  assign rd0_o = rd0_q;
  assign rd1_o = rd1_q;

endmodule

/* hw/rtl/hmts_fifo.sv */
module hmts_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] wdata_i,
  input  logic         pop_i,
  output logic [W-1:0] rdata_o,
  output logic         full_o,
  output logic         empty_o
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  logic [W-1:0]    buf_q [DEPTH];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  function automatic logic [PtrW-1:0] wrap_inc(logic [PtrW-1:0] p);
    return (p == PtrW'(DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wrap_inc(wr_q);
      if (pop_i) rd_q <= wrap_inc(rd_q);
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) buf_q[wr_q] <= wdata_i;
  end

  assign rdata_o = buf_q[rd_q];
  assign full_o  = cnt_q == CntW'(DEPTH);
  assign empty_o = cnt_q == '0;

endmodule

/* hw/rtl/hmts_front.sv */
module hmts_front #(
  parameter int MAX_GRID  = 256,
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               in_valid_i,
  input  logic                               operation_i,
  input  logic [hmts_pkg::CellW-1:0]         cell_x_i,
  input  logic [hmts_pkg::CellW-1:0]         cell_z_i,
  input  logic signed [hmts_pkg::HW-1:0]     height_value_i,
  input  logic signed [hmts_pkg::HW-1:0]     query_x_i,
  input  logic signed [hmts_pkg::HW-1:0]     query_z_i,
  input  logic [$clog2(MAX_GRID+1)-1:0]      len_i,
  input  logic [hmts_pkg::SpW-1:0]           sp_i,
  input  logic signed [hmts_pkg::HW-1:0]     origin_x_i,
  input  logic signed [hmts_pkg::HW-1:0]     origin_z_i,
  output logic                               valid_o,
  output logic                               op_o,
  output logic                               wen_o,
  output logic [$clog2(MAX_GRID)-1:0]        gx_o,
  output logic [$clog2(MAX_GRID)-1:0]        gz_o,
  output logic [FRAC_BITS:0]                 u_o,
  output logic [FRAC_BITS:0]                 v_o,
  output logic [hmts_pkg::HW-1:0]            hgt_o
);

  import hmts_pkg::*;

  localparam int LW   = $clog2(MAX_GRID + 1);
  localparam int GW   = $clog2(MAX_GRID);
  localparam int FW   = FRAC_BITS + 1;
  localparam int NS   = DivStages + 1;
  localparam int CmpW = (LW > CellW) ? LW : CellW;

  typedef struct packed {
    logic          op;
    logic          wen;
    logic [GW-1:0] cx;
    logic [GW-1:0] cz;
    logic [HW-1:0] hgt;
  } tag_t;

  function automatic logic [GW-1:0] cell_of(logic signed [PW-1:0] p, logic [LW-1:0] len);
    logic [PW-1:0] g;
    logic [PW-1:0] lim;
    lim = PW'(len) - PW'(2);
    g   = p[PW-1] ? '0 : PW'(p >>> FRAC_BITS);
    if (g > lim) g = lim;
    return GW'(g);
  endfunction

  function automatic logic [FW-1:0] frac_of(logic signed [PW-1:0] p, logic [GW-1:0] g);
    logic signed [PW:0] f;
    logic signed [PW:0] one;
    one = (PW+1)'(1) <<< FRAC_BITS;
    f   = (PW+1)'(p) - $signed((PW+1)'({g, {FRAC_BITS{1'b0}}}));
    if (f < 0) begin
      f = '0;
    end else if (f > one) begin
      f = one;
    end
    return FW'(f);
  endfunction

  // divider stages
  logic [NS-1:0] dv_q;
  tag_t          tag_q [NS];
  div_lane_t     lx_q  [NS];
  div_lane_t     lz_q  [NS];

  // locate stages
  logic                 l1v_q, l2v_q, l3v_q;
  tag_t                 l1_tag_q, l2_tag_q, l3_tag_q;
  logic signed [PW-1:0] l1_px_q, l1_pz_q, l2_px_q, l2_pz_q;
  logic [GW-1:0]        l2_gx_q, l2_gz_q, l3_gx_q, l3_gz_q;
  logic [FW-1:0]        l3_u_q, l3_v_q;

  logic signed [DivW-1:0] dx, dz;
  tag_t                   tag_in;

  assign dx = DivW'(query_x_i) - DivW'(origin_x_i);
  assign dz = DivW'(query_z_i) - DivW'(origin_z_i);

  always_comb begin
    tag_in.op  = operation_i;
    tag_in.wen = (CmpW'(cell_x_i) < CmpW'(len_i)) && (CmpW'(cell_z_i) < CmpW'(len_i));
    tag_in.cx  = GW'(cell_x_i);
    tag_in.cz  = GW'(cell_z_i);
    tag_in.hgt = height_value_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q  <= '0;
      l1v_q <= 1'b0;
      l2v_q <= 1'b0;
      l3v_q <= 1'b0;
    end else if (en_i) begin
      dv_q  <= {dv_q[NS-2:0], in_valid_i};
      l1v_q <= dv_q[NS-1];
      l2v_q <= l1v_q;
      l3v_q <= l2v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tag_q[0] <= tag_in;
      lx_q[0]  <= lane_init(dx);
      lz_q[0]  <= lane_init(dz);
      for (int s = 1; s < NS; s++) begin
        tag_q[s] <= tag_q[s-1];
        lx_q[s]  <= lane_run(lx_q[s-1], sp_i);
        lz_q[s]  <= lane_run(lz_q[s-1], sp_i);
      end
      l1_tag_q <= tag_q[NS-1];
      l1_px_q  <= lane_quot(lx_q[NS-1]);
      l1_pz_q  <= lane_quot(lz_q[NS-1]);
      l2_tag_q <= l1_tag_q;
      l2_px_q  <= l1_px_q;
      l2_pz_q  <= l1_pz_q;
      l2_gx_q  <= cell_of(l1_px_q, len_i);
      l2_gz_q  <= cell_of(l1_pz_q, len_i);
      l3_tag_q <= l2_tag_q;
      l3_gx_q  <= l2_gx_q;
      l3_gz_q  <= l2_gz_q;
      l3_u_q   <= frac_of(l2_px_q, l2_gx_q);
      l3_v_q   <= frac_of(l2_pz_q, l2_gz_q);
    end
  end

  // a height write carries its own cell through the grid-index fields
  assign valid_o = l3v_q;
  assign op_o    = l3_tag_q.op;
  assign wen_o   = l3_tag_q.wen;
  assign gx_o    = (l3_tag_q.op == OP_WRITE) ? l3_tag_q.cx : l3_gx_q;
  assign gz_o    = (l3_tag_q.op == OP_WRITE) ? l3_tag_q.cz : l3_gz_q;
  assign u_o     = l3_u_q;
  assign v_o     = l3_v_q;
  assign hgt_o   = l3_tag_q.hgt;

endmodule

/* hw/rtl/hmts_back.sv */
module hmts_back #(
  parameter int MAX_GRID  = 256,
  parameter int FRAC_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [$clog2(MAX_GRID+1)-1:0]   len_i,
  input  logic signed [hmts_pkg::HW-1:0]  origin_height_i,
  input  logic                            empty_i,
  input  logic                            op_i,
  input  logic                            wen_i,
  input  logic [$clog2(MAX_GRID)-1:0]     gx_i,
  input  logic [$clog2(MAX_GRID)-1:0]     gz_i,
  input  logic [FRAC_BITS:0]              u_i,
  input  logic [FRAC_BITS:0]              v_i,
  input  logic [hmts_pkg::HW-1:0]         hgt_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [hmts_pkg::HW-1:0]  sampled_height_o
);

  import hmts_pkg::*;

  localparam int LW = $clog2(MAX_GRID + 1);
  localparam int GW = $clog2(MAX_GRID);
  localparam int FW = FRAC_BITS + 1;
  localparam int AW = $clog2(MAX_GRID * MAX_GRID);
  localparam int MW = HW + FW + 1;
  localparam int SW = MW + 2;
  localparam int RW = SW - FRAC_BITS + 1;

  localparam logic [FW-1:0]        One  = FW'(1) << FRAC_BITS;
  localparam logic signed [SW-1:0] Half = SW'(1) <<< (FRAC_BITS - 1);

  logic en;

  // stage 1: address and weights
  logic              r1v_q, r1_op_q, r1_wen_q, r1_tri_q;
  logic [HW-1:0]     r1_hgt_q;
  logic [AW-1:0]     r1_base_q;
  logic [FW-1:0]     r1_w0_q, r1_w1_q, r1_w2_q;
  // stage 2: corner heights come out of the RAMs
  logic              r2v_q, r2_tri_q;
  logic [FW-1:0]     r2_w0_q, r2_w1_q, r2_w2_q;
  // stage 3 and 4
  logic              r3v_q, r4v_q;
  logic signed [MW-1:0] c0_q, c1_q, c2_q;
  logic signed [SW-1:0] sum_q;
  // output register
  logic              out_valid_q;
  logic [HW-1:0]     out_data_q;

  logic [FW:0]       uv;
  logic              tri_lo;
  logic [FW-1:0]     w0_d, w1_d, w2_d;
  logic [GW+LW-1:0]  row_prod;
  logic [AW-1:0]     base_d;
  logic              we;
  logic [AW-1:0]     ra_top0, ra_top1, ra_bot0, ra_bot1;
  logic [HW-1:0]     h00, h10, h01, h11, hsel;
  logic signed [MW-1:0] c0_d, c1_d, c2_d;
  logic signed [SW-1:0] sum_d;
  logic signed [RW-1:0] res;
  logic              fits;
  logic [HW-1:0]     sat_d;

  assign en    = !out_valid_q || out_ready_i;
  assign pop_o = en && !empty_i;

  // lower triangle when u <= 1 - v
  assign uv     = {1'b0, u_i} + {1'b0, v_i};
  assign tri_lo = uv <= {1'b0, One};
  assign w0_d   = tri_lo ? FW'({1'b0, One} - uv) : FW'(uv - {1'b0, One});
  assign w1_d   = tri_lo ? u_i : One - v_i;
  assign w2_d   = tri_lo ? v_i : One - u_i;

  assign row_prod = (GW+LW)'(gz_i) * (GW+LW)'(len_i);
  assign base_d   = AW'(row_prod) + AW'(gx_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r1v_q       <= 1'b0;
      r2v_q       <= 1'b0;
      r3v_q       <= 1'b0;
      r4v_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      r1v_q       <= !empty_i;
      r2v_q       <= r1v_q && (r1_op_q == OP_QUERY);
      r3v_q       <= r2v_q;
      r4v_q       <= r3v_q;
      out_valid_q <= r4v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r1_op_q    <= op_i;
      r1_wen_q   <= wen_i;
      r1_tri_q   <= tri_lo;
      r1_hgt_q   <= hgt_i;
      r1_base_q  <= base_d;
      r1_w0_q    <= w0_d;
      r1_w1_q    <= w1_d;
      r1_w2_q    <= w2_d;
      r2_tri_q   <= r1_tri_q;
      r2_w0_q    <= r1_w0_q;
      r2_w1_q    <= r1_w1_q;
      r2_w2_q    <= r1_w2_q;
      c0_q       <= c0_d;
      c1_q       <= c1_d;
      c2_q       <= c2_d;
      sum_q      <= sum_d;
      out_data_q <= sat_d;
    end
  end

  // two copies of the grid: one serves the lower row, one the upper row
  assign we      = en && r1v_q && (r1_op_q == OP_WRITE) && r1_wen_q;
  assign ra_top0 = r1_base_q;
  assign ra_top1 = r1_base_q + AW'(1);
  assign ra_bot0 = r1_base_q + AW'(len_i);
  assign ra_bot1 = ra_bot0 + AW'(1);

  hmts_ram #(
    .W     (HW),
    .DEPTH (MAX_GRID * MAX_GRID)
  ) u_ram_row0 (
    .clk_i (clk_i),
    .we_i  (we),
    .wa_i  (r1_base_q),
    .wd_i  (r1_hgt_q),
    .re_i  (en),
    .ra0_i (ra_top0),
    .ra1_i (ra_top1),
    .rd0_o (h00),
    .rd1_o (h10)
  );

  hmts_ram #(
    .W     (HW),
    .DEPTH (MAX_GRID * MAX_GRID)
  ) u_ram_row1 (
    .clk_i (clk_i),
    .we_i  (we),
    .wa_i  (r1_base_q),
    .wd_i  (r1_hgt_q),
    .re_i  (en),
    .ra0_i (ra_bot0),
    .ra1_i (ra_bot1),
    .rd0_o (h01),
    .rd1_o (h11)
  );

  assign hsel = r2_tri_q ? h00 : h11;
  assign c0_d = MW'($signed(hsel)) * MW'($signed({1'b0, r2_w0_q}));
  assign c1_d = MW'($signed(h10)) * MW'($signed({1'b0, r2_w1_q}));
  assign c2_d = MW'($signed(h01)) * MW'($signed({1'b0, r2_w2_q}));

  // rounding half folded into the sum
  assign sum_d = SW'(c0_q) + SW'(c1_q) + SW'(c2_q) + Half;

  assign res   = RW'(sum_q >>> FRAC_BITS) + RW'(origin_height_i);
  assign fits  = (res[RW-1:HW-1] == '0) || (res[RW-1:HW-1] == '1);
  assign sat_d = fits ? res[HW-1:0]
               : (res[RW-1] ? {1'b1, {(HW-1){1'b0}}} : {1'b0, {(HW-1){1'b1}}});

  assign out_valid_o      = out_valid_q;
  assign sampled_height_o = out_data_q;

endmodule

/* hw/rtl/heightmap_triangle_height_sampler_top.sv */
// Height grid sampler.
// Config channel (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i): index 0 grid
// length, 1 cell spacing, 2/3 origin x/z, 4 origin height. Always ready; write
// only while the block is idle. Other indexes are dropped.
// Input channel (in_valid_i/in_ready_o): operation 0 stores height_value_i at
// (cell_x_i, cell_z_i), operation 1 samples the grid at (query_x_i, query_z_i).
// Output channel (out_valid_o/out_ready_i): one sampled_height_o word per query,
// in order; writes give no word.
// Throughput: one word per cycle, sustained while the receiver does not stall. The
// accepting edge loads the front's input register; 14 more front stages follow (11
// stages of the 3-bit-per-stage offset divider, 3 for cell locate), then the queue,
// then 5 back stages (address, dual grid RAM read, multiply, sum, round and
// saturate).
// A 4-word queue sits between front and back. When the receiver stalls, the back
// holds, the queue fills and then in_ready_o drops.
// Reset clears all control state and loads the config defaults (length 256,
// spacing 1, origins 0); grid heights are undefined until written.
module heightmap_triangle_height_sampler_top #(
  parameter int MAX_GRID  = 256,
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [hmts_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [hmts_pkg::HW-1:0]            cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               operation_i,
  input  logic [hmts_pkg::CellW-1:0]         cell_x_i,
  input  logic [hmts_pkg::CellW-1:0]         cell_z_i,
  input  logic signed [hmts_pkg::HW-1:0]     height_value_i,
  input  logic signed [hmts_pkg::HW-1:0]     query_x_i,
  input  logic signed [hmts_pkg::HW-1:0]     query_z_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [hmts_pkg::HW-1:0]     sampled_height_o
);

  import hmts_pkg::*;

  localparam int LW  = $clog2(MAX_GRID + 1);
  localparam int GW  = $clog2(MAX_GRID);
  localparam int FW  = FRAC_BITS + 1;
  localparam int ClW = (LW > LenCfgW) ? LW : LenCfgW;
  localparam int QW  = 2 + 2 * GW + 2 * FW + HW;

  logic [LenCfgW-1:0]   grid_length_q;
  logic [SpW-1:0]       spacing_q;
  logic signed [HW-1:0] origin_x_q, origin_z_q, origin_height_q;

  logic [ClW-1:0] gl_ext;
  logic [LW-1:0]  len;
  logic [SpW-1:0] sp;

  logic          en_f;
  logic          f_valid, f_op, f_wen;
  logic [GW-1:0] f_gx, f_gz;
  logic [FW-1:0] f_u, f_v;
  logic [HW-1:0] f_hgt;

  logic          fifo_push, fifo_pop, fifo_full, fifo_empty;
  logic [QW-1:0] fifo_wdata, fifo_rdata;
  logic          b_op, b_wen;
  logic [GW-1:0] b_gx, b_gz;
  logic [FW-1:0] b_u, b_v;
  logic [HW-1:0] b_hgt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_length_q   <= LenCfgW'(256);
      spacing_q       <= SpW'(1);
      origin_x_q      <= '0;
      origin_z_q      <= '0;
      origin_height_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_GRID_LENGTH:   grid_length_q   <= cfg_data_i[LenCfgW-1:0];
        CFG_CELL_SPACING:  spacing_q       <= cfg_data_i[SpW-1:0];
        CFG_ORIGIN_X:      origin_x_q      <= cfg_data_i;
        CFG_ORIGIN_Z:      origin_z_q      <= cfg_data_i;
        CFG_ORIGIN_HEIGHT: origin_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  assign gl_ext = ClW'(grid_length_q);
  assign len    = (gl_ext < ClW'(2)) ? LW'(2)
                : (gl_ext > ClW'(MAX_GRID)) ? LW'(MAX_GRID) : LW'(gl_ext);
  assign sp     = (spacing_q == '0) ? SpW'(1) : spacing_q;

  // front advances whenever the queue can take its last stage
  assign en_f       = !fifo_full || fifo_pop;
  assign in_ready_o = en_f;
  assign fifo_push  = en_f && f_valid;

  hmts_front #(
    .MAX_GRID  (MAX_GRID),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (en_f),
    .in_valid_i     (in_valid_i),
    .operation_i    (operation_i),
    .cell_x_i       (cell_x_i),
    .cell_z_i       (cell_z_i),
    .height_value_i (height_value_i),
    .query_x_i      (query_x_i),
    .query_z_i      (query_z_i),
    .len_i          (len),
    .sp_i           (sp),
    .origin_x_i     (origin_x_q),
    .origin_z_i     (origin_z_q),
    .valid_o        (f_valid),
    .op_o           (f_op),
    .wen_o          (f_wen),
    .gx_o           (f_gx),
    .gz_o           (f_gz),
    .u_o            (f_u),
    .v_o            (f_v),
    .hgt_o          (f_hgt)
  );

  assign fifo_wdata = {f_op, f_wen, f_gx, f_gz, f_u, f_v, f_hgt};

  hmts_fifo #(
    .W     (QW),
    .DEPTH (QDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fifo_push),
    .wdata_i (fifo_wdata),
    .pop_i   (fifo_pop),
    .rdata_o (fifo_rdata),
    .full_o  (fifo_full),
    .empty_o (fifo_empty)
  );

  assign {b_op, b_wen, b_gx, b_gz, b_u, b_v, b_hgt} = fifo_rdata;

  hmts_back #(
    .MAX_GRID  (MAX_GRID),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .len_i            (len),
    .origin_height_i  (origin_height_q),
    .empty_i          (fifo_empty),
    .op_i             (b_op),
    .wen_i            (b_wen),
    .gx_i             (b_gx),
    .gz_i             (b_gz),
    .u_i              (b_u),
    .v_i              (b_v),
    .hgt_i            (b_hgt),
    .pop_o            (fifo_pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .sampled_height_o (sampled_height_o)
  );

`include "heightmap_triangle_height_sampler_top_assert.svh"

  `HMTS_ASSERT_IMP(a_queue_no_overflow, fifo_push && fifo_full, fifo_pop, "word pushed into full queue")
  `HMTS_ASSERT_IMP(a_queue_no_underflow, fifo_pop, !fifo_empty, "pop from empty queue")
  `HMTS_ASSERT_IMP(a_back_holds, out_valid_o && !out_ready_i, !fifo_pop, "back popped while output stalled")

endmodule
